### hdl/hrlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character codes and match patterns for the HTTP request
// line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // input beat: one received byte or a new-connection marker
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_in_chunk;
    } t_in_item;

    // result beat: one per input beat
    typedef struct packed {
        logic [1:0]         stored_kind;
        logic [7:0]         stored_byte;
        logic [6:0]         stored_index;
        logic               uri_done;
        logic               abort_conn;
        logic               request_done;
        logic [1:0]         method_seen;
        logic signed [31:0] body_left;
    } t_out_item;

    // parser phase
    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_HEADERS = 3'd2,
        PH_HEADER  = 3'd3,
        PH_PARAMS  = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    // position inside one header line
    typedef enum logic [2:0] {
        HS_NAME   = 3'd0,
        HS_COLON  = 3'd1,
        HS_SKIP   = 3'd2,
        HS_LEAD   = 3'd3,
        HS_DIGITS = 3'd4,
        HS_DONE   = 3'd5,
        HS_OTHER  = 3'd6
    } t_hsub;

    // item kinds
    localparam logic KIND_NEW_CONN = 1'b0;

    // stored kinds
    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_URI   = 2'd1;
    localparam logic [1:0] SK_PARAM = 2'd2;

    // methods
    localparam logic [1:0] METH_NONE = 2'd0;
    localparam logic [1:0] METH_GET  = 2'd1;
    localparam logic [1:0] METH_POST = 2'd2;

    // match positions
    localparam logic [2:0] MP_START  = 3'd0;
    localparam logic [2:0] MP_GET    = 3'd1;
    localparam logic [2:0] MP_GET_END  = 3'd3;
    localparam logic [2:0] MP_POST   = 3'd4;
    localparam logic [2:0] MP_POST_END = 3'd7;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    // length header name
    localparam logic [3:0] NAME_LEN  = 4'd14;
    localparam logic [3:0] NAME_LAST = 4'd13;

    // saturation limit of the length value
    localparam logic [34:0] VAL_MAX = 35'h0_7FFF_FFFF;

    // "Content-Length" by position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // method tails: "GET " at 1..3, "POST " at 4..7
    function automatic logic [7:0] meth_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd1:    c = 8'h45; // E
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h20; // space
            3'd4:    c = 8'h4F; // O
            3'd5:    c = 8'h53; // S
            3'd6:    c = 8'h54; // T
            3'd7:    c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/hrlp_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_engine
// Parser state and the single-pass update for one beat: method match,
// URI and parameter storage, header scan and Content-Length value.
// ----------------------------------------------------------------------------
module hrlp_engine #(
    parameter int URI_MAX    = 64,
    parameter int PARAMS_MAX = 64,
    parameter int HEADER_MAX = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  hrlp_pkg::t_in_item  i_item,
    output hrlp_pkg::t_out_item o_result
);

    localparam int UW = $clog2(URI_MAX + 1);
    localparam int PW = $clog2(PARAMS_MAX + 2);
    localparam int HW = $clog2(HEADER_MAX);

    localparam logic [UW-1:0] URI_LIMIT    = UW'(URI_MAX);
    localparam logic [PW-1:0] PARAMS_LIMIT = PW'(PARAMS_MAX);
    localparam logic [HW-1:0] HEADER_LIMIT = HW'(HEADER_MAX - 1);

    // state
    hrlp_pkg::t_phase r_phase, n_phase;
    hrlp_pkg::t_hsub  r_hsub, n_hsub;
    logic [2:0]       r_match, n_match;
    logic [1:0]       r_method, n_method;
    logic [UW-1:0]    r_uri_cnt, n_uri_cnt;
    logic [PW-1:0]    r_par_cnt, n_par_cnt;
    logic [HW-1:0]    r_hdr_cnt, n_hdr_cnt;
    logic [30:0]      r_acc, n_acc;
    logic             r_neg, n_neg;
    logic [31:0]      r_body, n_body;
    logic             r_skip, n_skip;

    // header byte feed
    hrlp_pkg::t_hsub  base_sub, f_sub;
    logic [30:0]      base_acc, f_acc;
    logic             base_neg, f_neg;
    logic [HW-1:0]    feed_idx;
    logic [7:0]       b;
    logic             is_digit;
    logic [3:0]       digit_val;
    logic [34:0]      acc_x10;

    // result fields
    logic [1:0] sk;
    logic [7:0] sb;
    logic [6:0] si;
    logic       udone, abrt, done;

    assign b         = i_item.data_byte;
    assign is_digit  = (b >= hrlp_pkg::CH_0) && (b <= hrlp_pkg::CH_9);
    assign digit_val = 4'(b - hrlp_pkg::CH_0);

    // first byte of a line starts from a clean name match
    always_comb begin
        if (r_phase == hrlp_pkg::PH_HEADERS) begin
            base_sub = hrlp_pkg::HS_NAME;
            base_acc = '0;
            base_neg = 1'b0;
            feed_idx = '0;
        end else begin
            base_sub = r_hsub;
            base_acc = r_acc;
            base_neg = r_neg;
            feed_idx = r_hdr_cnt;
        end
    end

    // acc * 10 + digit as shift and add
    assign acc_x10 = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + 35'(digit_val);

    // header sub-state step
    always_comb begin
        f_sub = base_sub;
        f_acc = base_acc;
        f_neg = base_neg;
        unique case (base_sub)
            hrlp_pkg::HS_NAME: begin
                if (feed_idx >= HW'(hrlp_pkg::NAME_LEN)
                    || b != hrlp_pkg::name_char(feed_idx[3:0])) begin
                    f_sub = hrlp_pkg::HS_OTHER;
                end else if (feed_idx == HW'(hrlp_pkg::NAME_LAST)) begin
                    f_sub = hrlp_pkg::HS_COLON;
                end
            end
            hrlp_pkg::HS_COLON: begin
                if (b == hrlp_pkg::CH_COLON) f_sub = hrlp_pkg::HS_SKIP;
            end
            hrlp_pkg::HS_SKIP: begin
                f_sub = hrlp_pkg::HS_LEAD;
            end
            hrlp_pkg::HS_LEAD: begin
                if (b == hrlp_pkg::CH_SP || b == hrlp_pkg::CH_TAB
                    || b == hrlp_pkg::CH_VT || b == hrlp_pkg::CH_FF) begin
                    f_sub = base_sub;
                end else if (b == hrlp_pkg::CH_PLUS) begin
                    f_sub = hrlp_pkg::HS_DIGITS;
                end else if (b == hrlp_pkg::CH_MINUS) begin
                    f_neg = 1'b1;
                    f_sub = hrlp_pkg::HS_DIGITS;
                end else if (is_digit) begin
                    f_acc = 31'(digit_val);
                    f_sub = hrlp_pkg::HS_DIGITS;
                end else begin
                    f_sub = hrlp_pkg::HS_DONE;
                end
            end
            hrlp_pkg::HS_DIGITS: begin
                if (is_digit) begin
                    f_acc = (acc_x10 > hrlp_pkg::VAL_MAX) ? 31'h7FFF_FFFF : acc_x10[30:0];
                end else begin
                    f_sub = hrlp_pkg::HS_DONE;
                end
            end
            default: begin
                f_sub = base_sub;
            end
        endcase
    end

    // next state and result for one beat
    always_comb begin
        n_phase   = r_phase;
        n_hsub    = r_hsub;
        n_match   = r_match;
        n_method  = r_method;
        n_uri_cnt = r_uri_cnt;
        n_par_cnt = r_par_cnt;
        n_hdr_cnt = r_hdr_cnt;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_body    = r_body;
        n_skip    = r_skip;
        sk        = hrlp_pkg::SK_NONE;
        sb        = '0;
        si        = '0;
        udone     = 1'b0;
        abrt      = 1'b0;
        done      = 1'b0;

        if (i_item.kind == hrlp_pkg::KIND_NEW_CONN) begin
            n_phase   = hrlp_pkg::PH_METHOD;
            n_hsub    = hrlp_pkg::HS_NAME;
            n_match   = hrlp_pkg::MP_START;
            n_method  = hrlp_pkg::METH_NONE;
            n_uri_cnt = '0;
            n_par_cnt = '0;
            n_hdr_cnt = '0;
            n_acc     = '0;
            n_neg     = 1'b0;
            n_body    = '1;
            n_skip    = 1'b0;
        end else if (r_phase != hrlp_pkg::PH_IDLE) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                unique case (r_phase)
                    hrlp_pkg::PH_METHOD: begin
                        if (r_match == hrlp_pkg::MP_START) begin
                            if (b == hrlp_pkg::CH_G) begin
                                n_match = hrlp_pkg::MP_GET;
                            end else if (b == hrlp_pkg::CH_P) begin
                                n_match = hrlp_pkg::MP_POST;
                            end else begin
                                abrt    = 1'b1;
                                n_phase = hrlp_pkg::PH_IDLE;
                            end
                        end else if (b == hrlp_pkg::meth_char(r_match)) begin
                            if (r_match == hrlp_pkg::MP_GET_END) begin
                                n_method = hrlp_pkg::METH_GET;
                                n_match  = hrlp_pkg::MP_START;
                                n_phase  = hrlp_pkg::PH_URI;
                            end else if (r_match == hrlp_pkg::MP_POST_END) begin
                                n_method = hrlp_pkg::METH_POST;
                                n_match  = hrlp_pkg::MP_START;
                                n_phase  = hrlp_pkg::PH_URI;
                            end else begin
                                n_match = r_match + 3'd1;
                            end
                        end else begin
                            abrt    = 1'b1;
                            n_phase = hrlp_pkg::PH_IDLE;
                        end
                    end
                    hrlp_pkg::PH_URI: begin
                        if (b == hrlp_pkg::CH_SP) begin
                            udone   = 1'b1;
                            n_phase = hrlp_pkg::PH_HEADERS;
                        end else if (b == hrlp_pkg::CH_QM) begin
                            udone   = 1'b1;
                            n_phase = hrlp_pkg::PH_PARAMS;
                        end else if (r_uri_cnt < URI_LIMIT) begin
                            sk        = hrlp_pkg::SK_URI;
                            sb        = b;
                            si        = 7'(r_uri_cnt);
                            n_uri_cnt = r_uri_cnt + UW'(1);
                        end
                    end
                    hrlp_pkg::PH_HEADERS: begin
                        if (b == hrlp_pkg::CH_CR || b == hrlp_pkg::CH_LF) begin
                            n_skip = (b == hrlp_pkg::CH_CR);
                            // blank line ends the header block
                            if (r_method == hrlp_pkg::METH_POST) begin
                                n_phase = hrlp_pkg::PH_PARAMS;
                            end else begin
                                done    = 1'b1;
                                n_phase = hrlp_pkg::PH_IDLE;
                            end
                        end else begin
                            n_hsub    = f_sub;
                            n_acc     = f_acc;
                            n_neg     = f_neg;
                            n_hdr_cnt = HW'(1);
                            n_phase   = hrlp_pkg::PH_HEADER;
                        end
                    end
                    hrlp_pkg::PH_HEADER: begin
                        if (b == hrlp_pkg::CH_CR || b == hrlp_pkg::CH_LF) begin
                            n_skip = (b == hrlp_pkg::CH_CR);
                            if (r_hsub == hrlp_pkg::HS_LEAD || r_hsub == hrlp_pkg::HS_DIGITS
                                || r_hsub == hrlp_pkg::HS_DONE) begin
                                n_body = (r_neg && r_acc != '0) ? '1 : {1'b0, r_acc};
                            end
                            n_phase = hrlp_pkg::PH_HEADERS;
                        end else if (r_hdr_cnt < HEADER_LIMIT) begin
                            n_hsub    = f_sub;
                            n_acc     = f_acc;
                            n_neg     = f_neg;
                            n_hdr_cnt = r_hdr_cnt + HW'(1);
                        end
                    end
                    hrlp_pkg::PH_PARAMS: begin
                        if (b == hrlp_pkg::CH_SP || b == hrlp_pkg::CH_CR
                            || b == hrlp_pkg::CH_LF) begin
                            // terminator may use one slot past the buffer
                            if (r_par_cnt <= PARAMS_LIMIT) begin
                                sk        = hrlp_pkg::SK_PARAM;
                                si        = 7'(r_par_cnt);
                                n_par_cnt = r_par_cnt + PW'(1);
                            end
                            if (b == hrlp_pkg::CH_SP) begin
                                n_phase = hrlp_pkg::PH_HEADERS;
                            end else begin
                                done    = 1'b1;
                                n_phase = hrlp_pkg::PH_IDLE;
                            end
                        end else if (r_par_cnt < PARAMS_LIMIT) begin
                            sk        = hrlp_pkg::SK_PARAM;
                            sb        = (b == hrlp_pkg::CH_AMP || b == hrlp_pkg::CH_EQ) ? 8'h00 : b;
                            si        = 7'(r_par_cnt);
                            n_par_cnt = r_par_cnt + PW'(1);
                        end
                        // body countdown, only with a known length
                        if (r_body != '0 && !r_body[31]) begin
                            n_body = r_body - 32'd1;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            // end of chunk with the whole body seen
            if (i_item.last_in_chunk && n_phase == hrlp_pkg::PH_PARAMS && n_body == '0) begin
                done    = 1'b1;
                n_phase = hrlp_pkg::PH_IDLE;
            end
        end
    end

    // result beat
    always_comb begin
        o_result.stored_kind  = sk;
        o_result.stored_byte  = sb;
        o_result.stored_index = si;
        o_result.uri_done     = udone;
        o_result.abort_conn   = abrt;
        o_result.request_done = done;
        o_result.method_seen  = n_method;
        o_result.body_left    = $signed(n_body);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hrlp_pkg::PH_IDLE;
            r_hsub    <= hrlp_pkg::HS_NAME;
            r_match   <= hrlp_pkg::MP_START;
            r_method  <= hrlp_pkg::METH_NONE;
            r_uri_cnt <= '0;
            r_par_cnt <= '0;
            r_hdr_cnt <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_body    <= '1;
            r_skip    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hsub    <= n_hsub;
            r_match   <= n_match;
            r_method  <= n_method;
            r_uri_cnt <= n_uri_cnt;
            r_par_cnt <= n_par_cnt;
            r_hdr_cnt <= n_hdr_cnt;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_body    <= n_body;
            r_skip    <= n_skip;
        end
    end

    // abort and completion both park the parser
    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.abort_conn |=> r_phase == hrlp_pkg::PH_IDLE)
        else $error("abort did not return parser to idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.request_done |=> r_phase == hrlp_pkg::PH_IDLE)
        else $error("request completion did not return parser to idle");

    // end of URI only once a method is known
    a_uri_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.uri_done |-> o_result.method_seen != hrlp_pkg::METH_NONE)
        else $error("URI ended without a method");

    // a stored byte never comes with an abort
    a_store_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.abort_conn |-> o_result.stored_kind == hrlp_pkg::SK_NONE)
        else $error("byte stored on abort");

endmodule
`default_nettype wire

### hdl/http_request_line_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Byte-serial HTTP request parser: method match, URI and parameter bytes,
// Content-Length scan, completion and abort flags.
//
//   channel | direction | handshake             | payload
//   in      | sink      | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out     | source    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// one beat in gives one beat out; a beat is taken every cycle when the
// output is not stalled. each beat passes the input register, then the
// single-pass state update into the output register.
// reset (i_rst_n low, synchronous) leaves the parser idle with no length.
// a stalled output holds its beat; the input register still takes one more.
// ----------------------------------------------------------------------------
module http_request_line_parser_top #(
    parameter int URI_MAX    = 64,
    parameter int PARAMS_MAX = 64,
    parameter int HEADER_MAX = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  hrlp_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output hrlp_pkg::t_out_item o_out_data,
    input  wire                 i_out_stall
);

    logic                r_in_valid;
    hrlp_pkg::t_in_item  r_in;
    logic                r_out_valid;
    hrlp_pkg::t_out_item r_out;
    hrlp_pkg::t_out_item result;
    logic                advance;
    logic                in_take;

    // move the held beat through the engine when the output slot frees
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    hrlp_engine #(
        .URI_MAX    (URI_MAX),
        .PARAMS_MAX (PARAMS_MAX),
        .HEADER_MAX (HEADER_MAX)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
